>>> src/hhln_pkg.sv
// ----------------------------------------------------------------------------
// hhln_pkg
// Types, constants and byte-class helpers for the HTTP header line normalizer.
// ----------------------------------------------------------------------------
package hhln_pkg;

    // Block size limit and saturation point of the emitted-byte count
    localparam int MAX_BLOCK_BYTES = 16384;
    localparam int COUNT_W         = 15;
    localparam int COUNT_MAX       = (1 << COUNT_W) - 1;
    localparam int COUNT_CAP_INT   = (MAX_BLOCK_BYTES > COUNT_MAX) ? COUNT_MAX
                                                                   : MAX_BLOCK_BYTES;
    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_CAP_INT[COUNT_W-1:0];

    // Result queue depth (a word can push two results)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = QPTR_W + 1;

    // Characters with special meaning
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // Parse phases; unused codes behave as drain
    typedef enum logic [2:0] {
        PH_SKIP_KEY  = 3'd0,
        PH_KEY       = 3'd1,
        PH_SKIP_VAL  = 3'd2,
        PH_VALUE     = 3'd3,
        PH_EXPECT_LF = 3'd4,
        PH_DRAIN     = 3'd5
    } phase_t;

    // One result word
    typedef struct packed {
        logic [7:0]         data;
        logic               byte_valid;
        logic               is_last;
        logic               status;
        logic [COUNT_W-1:0] count;
    } result_t;

    // Printable: 0x21..0x7E
    function automatic logic is_printable(input logic [7:0] b);
        return (b > CH_SPACE) && (b <= CH_TILDE);
    endfunction

    // Fold upper-case ASCII to lower case
    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'h20) : b;
    endfunction

    // Saturating increment of the emitted-byte count
    function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] c);
        return (c < COUNT_CAP) ? (c + 1'b1) : c;
    endfunction

endpackage

>>> src/http_header_line_normalizer.sv
// ----------------------------------------------------------------------------
// http_header_line_normalizer
// Rewrites "key:value CRLF" header lines as "key: value CRLF", folding the
// key to lower case, and flags malformed header blocks.
// ----------------------------------------------------------------------------
// Takes one header byte per cycle while in_ready is high; a zero byte ends the
// block. Each accepted word is classified combinationally against the current
// parse phase and its results (none, one, or two for a colon) are pushed into
// a four-entry result queue whose head drives the output ports. in_ready
// stays high while the queue has room for two results, so a stream sustains
// one input word per cycle with one result word out per cycle; each colon adds
// one extra result word, and the input pauses when the queue fills faster than
// the output drains it, either from colons close together or from output
// stalls. On error a terminating word with status 1 is sent and further bytes
// are dropped up to and including the zero byte.
// out_count saturates at the smaller of MAX_BLOCK_BYTES and 32767.
module http_header_line_normalizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_byte,
    output logic                          byte_valid,
    output logic                          is_last,
    output logic                          status,
    output logic [hhln_pkg::COUNT_W-1:0]  out_count
);
    import hhln_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    result_t            queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QFILL_W-1:0] fill_reg, fill_next;

    logic               accept;
    logic               pop;
    logic [1:0]         push_cnt;
    result_t            res0, res1;
    logic [COUNT_W-1:0] cnt1, cnt2;

    // Handshake
    assign in_ready  = (fill_reg <= QFILL_W'(QUEUE_DEPTH - 2));
    assign out_valid = (fill_reg != '0);
    assign accept    = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Counts after one and two emitted bytes
    assign cnt1 = count_inc(count_reg);
    assign cnt2 = count_inc(cnt1);

    // Classify the incoming word against the parse phase
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        push_cnt   = 2'd0;
        res0       = '0;
        res1       = '0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SKIP_KEY, PH_KEY:
                begin
                    if ((phase_reg == PH_SKIP_KEY) && (in_byte == CH_NUL))
                    begin
                        // end of block, well formed
                        res0       = '{data: 8'h00, byte_valid: 1'b0, is_last: 1'b1,
                                       status: 1'b0, count: count_reg};
                        push_cnt   = 2'd1;
                        phase_next = PH_SKIP_KEY;
                        count_next = '0;
                    end
                    else if ((phase_reg == PH_SKIP_KEY) && !is_printable(in_byte))
                    begin
                        // skip leading filler
                    end
                    else if (in_byte == CH_COLON)
                    begin
                        res0       = '{data: CH_COLON, byte_valid: 1'b1, is_last: 1'b0,
                                       status: 1'b0, count: cnt1};
                        res1       = '{data: CH_SPACE, byte_valid: 1'b1, is_last: 1'b0,
                                       status: 1'b0, count: cnt2};
                        push_cnt   = 2'd2;
                        count_next = cnt2;
                        phase_next = PH_SKIP_VAL;
                    end
                    else if (is_printable(in_byte))
                    begin
                        res0       = '{data: to_lower(in_byte), byte_valid: 1'b1,
                                       is_last: 1'b0, status: 1'b0, count: cnt1};
                        push_cnt   = 2'd1;
                        count_next = cnt1;
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        res0     = '{data: 8'h00, byte_valid: 1'b0, is_last: 1'b1,
                                     status: 1'b1, count: count_reg};
                        push_cnt = 2'd1;
                        if (in_byte == CH_NUL)
                        begin
                            phase_next = PH_SKIP_KEY;
                            count_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_DRAIN;
                        end
                    end
                end
                PH_SKIP_VAL:
                begin
                    if (in_byte == CH_NUL)
                    begin
                        res0       = '{data: 8'h00, byte_valid: 1'b0, is_last: 1'b1,
                                       status: 1'b0, count: count_reg};
                        push_cnt   = 2'd1;
                        phase_next = PH_SKIP_KEY;
                        count_next = '0;
                    end
                    else if (!is_printable(in_byte))
                    begin
                        // skip spaces and other non-printable bytes before the value
                    end
                    else if (in_byte == CH_TILDE)
                    begin
                        res0       = '{data: 8'h00, byte_valid: 1'b0, is_last: 1'b1,
                                       status: 1'b1, count: count_reg};
                        push_cnt   = 2'd1;
                        phase_next = PH_DRAIN;
                    end
                    else
                    begin
                        res0       = '{data: in_byte, byte_valid: 1'b1, is_last: 1'b0,
                                       status: 1'b0, count: cnt1};
                        push_cnt   = 2'd1;
                        count_next = cnt1;
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    if (((in_byte >= CH_SPACE) && (in_byte < CH_TILDE)) ||
                        (in_byte == CH_CR))
                    begin
                        res0       = '{data: in_byte, byte_valid: 1'b1, is_last: 1'b0,
                                       status: 1'b0, count: cnt1};
                        push_cnt   = 2'd1;
                        count_next = cnt1;
                        if (in_byte == CH_CR)
                        begin
                            phase_next = PH_EXPECT_LF;
                        end
                    end
                    else
                    begin
                        res0     = '{data: 8'h00, byte_valid: 1'b0, is_last: 1'b1,
                                     status: 1'b1, count: count_reg};
                        push_cnt = 2'd1;
                        if (in_byte == CH_NUL)
                        begin
                            phase_next = PH_SKIP_KEY;
                            count_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_DRAIN;
                        end
                    end
                end
                PH_EXPECT_LF:
                begin
                    if (in_byte == CH_LF)
                    begin
                        res0       = '{data: in_byte, byte_valid: 1'b1, is_last: 1'b0,
                                       status: 1'b0, count: cnt1};
                        push_cnt   = 2'd1;
                        count_next = cnt1;
                        phase_next = PH_SKIP_KEY;
                    end
                    else
                    begin
                        res0     = '{data: 8'h00, byte_valid: 1'b0, is_last: 1'b1,
                                     status: 1'b1, count: count_reg};
                        push_cnt = 2'd1;
                        if (in_byte == CH_NUL)
                        begin
                            phase_next = PH_SKIP_KEY;
                            count_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_DRAIN;
                        end
                    end
                end
                default:
                begin
                    // drop everything up to and including the zero byte
                    if (in_byte == CH_NUL)
                    begin
                        phase_next = PH_SKIP_KEY;
                        count_next = '0;
                    end
                end
            endcase
        end
    end

    // Advance queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        fill_next   = fill_reg + QFILL_W'(push_cnt) - QFILL_W'(pop);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SKIP_KEY;
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Write result words into the queue
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2)
        begin
            queue_reg[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    // Drive the output word from the queue head
    assign out_byte   = queue_reg[rd_ptr_reg].data;
    assign byte_valid = queue_reg[rd_ptr_reg].byte_valid;
    assign is_last    = queue_reg[rd_ptr_reg].is_last;
    assign status     = queue_reg[rd_ptr_reg].status;
    assign out_count  = queue_reg[rd_ptr_reg].count;

endmodule
